FILE: rtl/core/mouse_event_queue_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Mouse event queue encoder - assertion macros
// Concurrent assertion forms used by meq_dp.
// ----------------------------------------------------------------------------
`ifndef MOUSE_EVENT_QUEUE_ENCODER_UNIT_DEFINES_SVH
`define MOUSE_EVENT_QUEUE_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define MEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("meq: assertion failed");

// next-cycle implication
`define MEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("meq: assertion failed");

`endif

FILE: rtl/core/meq_pkg.sv
// ----------------------------------------------------------------------------
// meq_pkg
// Types, codes and defaults shared by the mouse event queue encoder.
// ----------------------------------------------------------------------------
package meq_pkg;

    localparam int EVENT_DEPTH_DEF = 256;
    localparam int RAW_DEPTH_DEF   = 768;

    localparam int DELTA_W = 16;
    localparam int BTN_W   = 3;
    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int TYPE_W  = 2;
    localparam int CODE_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int BODY_W  = TYPE_W + CODE_W + DELTA_W;
    localparam int STAMP_W = SEC_W + USEC_W;
    localparam int ENTRY_W = BODY_W + STAMP_W;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP_EV  = 2'd1,
        ACT_POP_RAW = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    localparam logic [TYPE_W-1:0] TYPE_SYNC = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_KEY  = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_REL  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_X        = 9'd0;
    localparam logic [CODE_W-1:0] CODE_Y        = 9'd1;
    localparam logic [CODE_W-1:0] CODE_WHEEL    = 9'd8;
    localparam logic [CODE_W-1:0] CODE_SYNC     = 9'd0;
    localparam logic [CODE_W-1:0] CODE_BTN_LEFT = 9'd272;
    localparam logic [CODE_W-1:0] CODE_BTN_RGHT = 9'd273;
    localparam logic [CODE_W-1:0] CODE_BTN_MID  = 9'd274;

    // PS/2 flag byte bits
    localparam logic [BYTE_W-1:0] PS2_ALWAYS1 = 8'h08;
    localparam logic [BYTE_W-1:0] PS2_XSIGN   = 8'h10;
    localparam logic [BYTE_W-1:0] PS2_YSIGN   = 8'h20;

    typedef logic [2:0] t_slot;

    localparam t_slot SLOT_X     = 3'd0;
    localparam t_slot SLOT_Y     = 3'd1;
    localparam t_slot SLOT_WHEEL = 3'd2;
    localparam t_slot SLOT_LEFT  = 3'd3;
    localparam t_slot SLOT_RIGHT = 3'd4;
    localparam t_slot SLOT_MID   = 3'd5;
    localparam t_slot SLOT_SYNC  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_PUSH   = 2'd1,
        ST_POP_WB = 2'd2
    } t_state;

    typedef struct packed {
        logic  push_start;
        logic  ev_pop_start;
        logic  raw_pop_start;
        logic  slot_wr;
        t_slot slot;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/meq_ctrl.sv
// ----------------------------------------------------------------------------
// meq_ctrl
// Sequencer: accepts one item, steps the seven event slots of a push,
// hands a pop result to the output register.
// ----------------------------------------------------------------------------
module meq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_action,
    output logic            o_ready,
    input  meq_pkg::t_sts   i_sts,
    output meq_pkg::t_cmd   o_cmd
);

    meq_pkg::t_state r_state, n_state;
    meq_pkg::t_slot  r_slot, n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= meq_pkg::ST_IDLE;
            r_slot  <= meq_pkg::SLOT_X;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.slot = r_slot;
        case (r_state)
            meq_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (meq_pkg::t_action'(i_action))
                        meq_pkg::ACT_PUSH: begin
                            o_cmd.push_start = 1'b1;
                            n_state = meq_pkg::ST_PUSH;
                            n_slot  = meq_pkg::SLOT_X;
                        end
                        meq_pkg::ACT_POP_EV: begin
                            o_cmd.ev_pop_start = 1'b1;
                            n_state = meq_pkg::ST_POP_WB;
                        end
                        meq_pkg::ACT_POP_RAW: begin
                            o_cmd.raw_pop_start = 1'b1;
                            n_state = meq_pkg::ST_POP_WB;
                        end
                        default: begin
                            n_state = meq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            meq_pkg::ST_PUSH: begin
                o_cmd.slot_wr = 1'b1;
                if (r_slot == meq_pkg::SLOT_SYNC) begin
                    n_state = meq_pkg::ST_IDLE;
                end else begin
                    n_slot = r_slot + 3'd1;
                end
            end
            meq_pkg::ST_POP_WB: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = meq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = meq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/meq_dp.sv
// ----------------------------------------------------------------------------
// meq_dp
// Datapath: event ring, PS/2 byte ring, push encoding, output register.
// ----------------------------------------------------------------------------
`include "mouse_event_queue_encoder_unit_defines.svh"

module meq_dp #(
    parameter int EVENT_DEPTH = meq_pkg::EVENT_DEPTH_DEF,
    parameter int RAW_DEPTH   = meq_pkg::RAW_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  meq_pkg::t_cmd                      i_cmd,
    output meq_pkg::t_sts                      o_sts,
    input  logic signed [meq_pkg::DELTA_W-1:0] i_delta_x,
    input  logic signed [meq_pkg::DELTA_W-1:0] i_delta_y,
    input  logic signed [meq_pkg::DELTA_W-1:0] i_delta_wheel,
    input  logic [meq_pkg::BTN_W-1:0]          i_buttons,
    input  logic [meq_pkg::SEC_W-1:0]          i_stamp_sec,
    input  logic [meq_pkg::USEC_W-1:0]         i_stamp_usec,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_found,
    output logic [meq_pkg::TYPE_W-1:0]         o_event_type,
    output logic [meq_pkg::CODE_W-1:0]         o_event_code,
    output logic signed [meq_pkg::DELTA_W-1:0] o_event_value,
    output logic [meq_pkg::SEC_W-1:0]          o_event_sec,
    output logic [meq_pkg::USEC_W-1:0]         o_event_usec,
    output logic [meq_pkg::BYTE_W-1:0]         o_raw_byte
);

    localparam int EV_AW  = $clog2(EVENT_DEPTH);
    localparam int EV_FW  = $clog2(EVENT_DEPTH + 1);
    localparam int RAW_AW = $clog2(RAW_DEPTH);
    localparam int RAW_FW = $clog2(RAW_DEPTH + 1);

    localparam logic [EV_AW-1:0]  EV_LAST   = EV_AW'(EVENT_DEPTH - 1);
    localparam logic [EV_FW-1:0]  EV_FULL   = EV_FW'(EVENT_DEPTH);
    localparam logic [RAW_AW-1:0] RAW_LAST  = RAW_AW'(RAW_DEPTH - 1);
    localparam logic [RAW_FW+1:0] RAW_LIMIT = (RAW_FW + 2)'(RAW_DEPTH);

    // storage
    logic [meq_pkg::ENTRY_W-1:0] r_ev_mem [EVENT_DEPTH];
    logic [meq_pkg::BYTE_W-1:0]  r_raw_mem [RAW_DEPTH];

    logic [EV_AW-1:0]  r_ev_rd_ptr, r_ev_wr_ptr;
    logic [EV_FW-1:0]  r_ev_fill;
    logic [RAW_AW-1:0] r_raw_rd_ptr, r_raw_wr_ptr;
    logic [RAW_FW-1:0] r_raw_fill;
    logic [meq_pkg::BTN_W-1:0] r_prev_btn;

    // latched push item
    logic [meq_pkg::DELTA_W-1:0] r_dx, r_dy, r_dz;
    logic [meq_pkg::BTN_W-1:0]   r_btn;
    logic [meq_pkg::STAMP_W-1:0] r_stamp;
    logic [6:0]                  r_ev_mask;
    logic                        r_raw_ok;

    // pop bookkeeping
    logic [meq_pkg::ENTRY_W-1:0] r_ev_rd_data;
    logic [meq_pkg::BYTE_W-1:0]  r_raw_rd_data;
    logic                        r_pop_ev;
    logic                        r_pop_found;

    // output register
    logic                        r_out_valid;
    logic                        r_o_found;
    logic [meq_pkg::TYPE_W-1:0]  r_o_type;
    logic [meq_pkg::CODE_W-1:0]  r_o_code;
    logic [meq_pkg::DELTA_W-1:0] r_o_value;
    logic [meq_pkg::SEC_W-1:0]   r_o_sec;
    logic [meq_pkg::USEC_W-1:0]  r_o_usec;
    logic [meq_pkg::BYTE_W-1:0]  r_o_byte;

    logic [meq_pkg::BTN_W-1:0]   changed;
    logic [2:0]                  rel_nz;
    logic                        raw_fits;

    logic                        ev_we;
    logic [meq_pkg::TYPE_W-1:0]  ev_type;
    logic [meq_pkg::CODE_W-1:0]  ev_code;
    logic [meq_pkg::DELTA_W-1:0] ev_value;
    logic                        raw_we;
    logic [meq_pkg::BYTE_W-1:0]  raw_data;
    logic                        ev_full;
    logic                        ev_pop_hit;
    logic [EV_FW-1:0]            ev_fill_dec;

    assign changed     = i_buttons ^ r_prev_btn;
    assign rel_nz      = {i_delta_wheel != '0, i_delta_y != '0, i_delta_x != '0};
    assign raw_fits    = ({2'b00, r_raw_fill} + (RAW_FW + 2)'(3)) <= RAW_LIMIT;
    assign ev_full     = (r_ev_fill == EV_FULL);
    assign ev_pop_hit  = i_cmd.ev_pop_start && (r_ev_fill != '0);
    assign ev_fill_dec = r_ev_fill - EV_FW'(1);

    // event slot encode
    always_comb begin
        ev_we    = 1'b0;
        ev_type  = meq_pkg::TYPE_SYNC;
        ev_code  = meq_pkg::CODE_SYNC;
        ev_value = '0;
        case (i_cmd.slot)
            meq_pkg::SLOT_X: begin
                ev_we    = r_ev_mask[0];
                ev_type  = meq_pkg::TYPE_REL;
                ev_code  = meq_pkg::CODE_X;
                ev_value = r_dx;
            end
            meq_pkg::SLOT_Y: begin
                ev_we    = r_ev_mask[1];
                ev_type  = meq_pkg::TYPE_REL;
                ev_code  = meq_pkg::CODE_Y;
                ev_value = r_dy;
            end
            meq_pkg::SLOT_WHEEL: begin
                ev_we    = r_ev_mask[2];
                ev_type  = meq_pkg::TYPE_REL;
                ev_code  = meq_pkg::CODE_WHEEL;
                ev_value = r_dz;
            end
            meq_pkg::SLOT_LEFT: begin
                ev_we    = r_ev_mask[3];
                ev_type  = meq_pkg::TYPE_KEY;
                ev_code  = meq_pkg::CODE_BTN_LEFT;
                ev_value = {{(meq_pkg::DELTA_W-1){1'b0}}, r_btn[0]};
            end
            meq_pkg::SLOT_RIGHT: begin
                ev_we    = r_ev_mask[4];
                ev_type  = meq_pkg::TYPE_KEY;
                ev_code  = meq_pkg::CODE_BTN_RGHT;
                ev_value = {{(meq_pkg::DELTA_W-1){1'b0}}, r_btn[1]};
            end
            meq_pkg::SLOT_MID: begin
                ev_we    = r_ev_mask[5];
                ev_type  = meq_pkg::TYPE_KEY;
                ev_code  = meq_pkg::CODE_BTN_MID;
                ev_value = {{(meq_pkg::DELTA_W-1){1'b0}}, r_btn[2]};
            end
            meq_pkg::SLOT_SYNC: begin
                ev_we    = r_ev_mask[6];
            end
            default: begin
                ev_we    = 1'b0;
            end
        endcase
        ev_we = ev_we & i_cmd.slot_wr;
    end

    // PS/2 packet bytes ride on the first three slots
    always_comb begin
        raw_we   = 1'b0;
        raw_data = '0;
        case (i_cmd.slot)
            meq_pkg::SLOT_X: begin
                raw_we   = 1'b1;
                raw_data = meq_pkg::PS2_ALWAYS1
                         | {{(meq_pkg::BYTE_W-meq_pkg::BTN_W){1'b0}}, r_btn}
                         | (r_dx[meq_pkg::DELTA_W-1] ? meq_pkg::PS2_XSIGN : '0)
                         | (r_dy[meq_pkg::DELTA_W-1] ? meq_pkg::PS2_YSIGN : '0);
            end
            meq_pkg::SLOT_Y: begin
                raw_we   = 1'b1;
                raw_data = r_dx[meq_pkg::BYTE_W-1:0];
            end
            meq_pkg::SLOT_WHEEL: begin
                raw_we   = 1'b1;
                raw_data = r_dy[meq_pkg::BYTE_W-1:0];
            end
            default: begin
                raw_we   = 1'b0;
            end
        endcase
        raw_we = raw_we & r_raw_ok & i_cmd.slot_wr;
    end

    // push latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_start) begin
            r_dx      <= i_delta_x;
            r_dy      <= i_delta_y;
            r_dz      <= i_delta_wheel;
            r_btn     <= i_buttons;
            r_stamp   <= {i_stamp_sec, i_stamp_usec};
            r_ev_mask <= {(|rel_nz) | (|changed), changed, rel_nz};
            r_raw_ok  <= raw_fits;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (ev_we) begin
            r_ev_mem[r_ev_wr_ptr] <= {ev_type, ev_code, ev_value, r_stamp};
        end
        if (i_cmd.ev_pop_start) begin
            r_ev_rd_data <= r_ev_mem[r_ev_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (raw_we) begin
            r_raw_mem[r_raw_wr_ptr] <= raw_data;
        end
        if (i_cmd.raw_pop_start) begin
            r_raw_rd_data <= r_raw_mem[r_raw_rd_ptr];
        end
    end

    // ring pointers and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_rd_ptr  <= '0;
            r_ev_wr_ptr  <= '0;
            r_ev_fill    <= '0;
            r_raw_rd_ptr <= '0;
            r_raw_wr_ptr <= '0;
            r_raw_fill   <= '0;
            r_prev_btn   <= '0;
        end else begin
            if (i_cmd.push_start) begin
                r_prev_btn <= i_buttons;
                if (raw_fits) begin
                    r_raw_fill <= r_raw_fill + RAW_FW'(3);
                end
            end
            if (ev_we) begin
                r_ev_wr_ptr <= (r_ev_wr_ptr == EV_LAST) ? '0 : r_ev_wr_ptr + EV_AW'(1);
                // full ring: oldest entry goes
                if (ev_full) begin
                    r_ev_rd_ptr <= (r_ev_rd_ptr == EV_LAST) ? '0
                                 : r_ev_rd_ptr + EV_AW'(1);
                end else begin
                    r_ev_fill <= r_ev_fill + EV_FW'(1);
                end
            end
            if (raw_we) begin
                r_raw_wr_ptr <= (r_raw_wr_ptr == RAW_LAST) ? '0
                              : r_raw_wr_ptr + RAW_AW'(1);
            end
            if (ev_pop_hit) begin
                r_ev_rd_ptr <= (r_ev_rd_ptr == EV_LAST) ? '0 : r_ev_rd_ptr + EV_AW'(1);
                r_ev_fill   <= ev_fill_dec;
            end
            if (i_cmd.raw_pop_start && r_raw_fill != '0) begin
                r_raw_rd_ptr <= (r_raw_rd_ptr == RAW_LAST) ? '0
                              : r_raw_rd_ptr + RAW_AW'(1);
                r_raw_fill   <= r_raw_fill - RAW_FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_pop_start) begin
            r_pop_ev    <= 1'b1;
            r_pop_found <= (r_ev_fill != '0);
        end else if (i_cmd.raw_pop_start) begin
            r_pop_ev    <= 1'b0;
            r_pop_found <= (r_raw_fill != '0);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_found <= r_pop_found;
            if (r_pop_found && r_pop_ev) begin
                {r_o_type, r_o_code, r_o_value, r_o_sec, r_o_usec} <= r_ev_rd_data;
            end else begin
                {r_o_type, r_o_code, r_o_value, r_o_sec, r_o_usec} <= '0;
            end
            r_o_byte <= (r_pop_found && !r_pop_ev) ? r_raw_rd_data : '0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_o_found;
    assign o_event_type  = r_o_type;
    assign o_event_code  = r_o_code;
    assign o_event_value = r_o_value;
    assign o_event_sec   = r_o_sec;
    assign o_event_usec  = r_o_usec;
    assign o_raw_byte    = r_o_byte;

    `MEQ_ASSERT_IMP(a_ev_fill_bound, i_clk, i_rst_n, 1'b1, r_ev_fill <= EV_FULL)
    `MEQ_ASSERT_IMP(a_raw_fill_bound, i_clk, i_rst_n, 1'b1, {2'b00, r_raw_fill} <= RAW_LIMIT)
    `MEQ_ASSERT_NXT(a_ev_pop_dec, i_clk, i_rst_n, ev_pop_hit, r_ev_fill == $past(ev_fill_dec))
    `MEQ_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready)

endmodule

FILE: rtl/core/mouse_event_queue_encoder_unit.sv
// ----------------------------------------------------------------------------
// mouse_event_queue_encoder_unit
// Mouse push encoder with a timestamped event ring and a PS/2 byte ring.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+--------------------------------------
//   input   | in  | i_valid / o_ready | action, deltas, buttons, timestamp
//   result  | out | o_valid / i_ready | found, event fields, raw byte
//
// Push: accept, then the seven event slots in turn (one event ring write
// port, one slot per cycle; PS/2 bytes go out in the first three slots).
// No result. Pop: accept, registered memory read, load of the output
// register; the next item is taken after the load, which waits while the
// output register is still full. Unused action code: accepted, no result.
// Synchronous active-low reset; stores hold no reset and need no clearing pass.
// ----------------------------------------------------------------------------
module mouse_event_queue_encoder_unit #(
    parameter int EVENT_DEPTH = meq_pkg::EVENT_DEPTH_DEF,
    parameter int RAW_DEPTH   = meq_pkg::RAW_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_action,
    input  logic signed [meq_pkg::DELTA_W-1:0] i_delta_x,
    input  logic signed [meq_pkg::DELTA_W-1:0] i_delta_y,
    input  logic signed [meq_pkg::DELTA_W-1:0] i_delta_wheel,
    input  logic [meq_pkg::BTN_W-1:0]          i_buttons,
    input  logic [meq_pkg::SEC_W-1:0]          i_stamp_sec,
    input  logic [meq_pkg::USEC_W-1:0]         i_stamp_usec,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_found,
    output logic [meq_pkg::TYPE_W-1:0]         o_event_type,
    output logic [meq_pkg::CODE_W-1:0]         o_event_code,
    output logic signed [meq_pkg::DELTA_W-1:0] o_event_value,
    output logic [meq_pkg::SEC_W-1:0]          o_event_sec,
    output logic [meq_pkg::USEC_W-1:0]         o_event_usec,
    output logic [meq_pkg::BYTE_W-1:0]         o_raw_byte
);

    meq_pkg::t_cmd cmd;
    meq_pkg::t_sts sts;

    meq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    meq_dp #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .RAW_DEPTH   (RAW_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_delta_x     (i_delta_x),
        .i_delta_y     (i_delta_y),
        .i_delta_wheel (i_delta_wheel),
        .i_buttons     (i_buttons),
        .i_stamp_sec   (i_stamp_sec),
        .i_stamp_usec  (i_stamp_usec),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_found       (o_found),
        .o_event_type  (o_event_type),
        .o_event_code  (o_event_code),
        .o_event_value (o_event_value),
        .o_event_sec   (o_event_sec),
        .o_event_usec  (o_event_usec),
        .o_raw_byte    (o_raw_byte)
    );

endmodule
